// ===== hw/rtl/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants of the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package salc_pkg;

   localparam int OP_W          = 2;
   localparam int ADDR_PORT_W   = 64;
   localparam int CNT_W         = 32;
   localparam int OUTCOME_W     = 2;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 6;
   localparam int SET_BITS_W    = 3;
   localparam int BLOCK_BITS_W  = 6;
   localparam int WAYS_W        = 4;
   localparam int RAW_IDX_W     = 7;
   localparam int ACTIVE_W      = 6;

   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
   localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

   localparam logic [OUTCOME_W-1:0] OUTCOME_HIT   = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_FILL  = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_EVICT = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAYS       = 2'd2;

   typedef struct packed {
      logic capture;
      logic commit;
   } salc_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_UPDATE = 2'b10
   } salc_state_type;

endpackage

// ===== hw/rtl/salc_ctrl.sv =====
// ----------------------------------------------------------------------------
// salc_ctrl
// Sequencer: takes a request, runs the set update, and holds the response
// valid flag until the receiver takes the beat.
// ----------------------------------------------------------------------------
module salc_ctrl
   import salc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output salc_cmd_type cmd
);

   salc_state_type state_ff;
   salc_state_type state_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           out_free;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == ST_IDLE);
   assign cmd.capture = (state_ff == ST_IDLE) && req_valid;
   assign cmd.commit  = (state_ff == ST_UPDATE) && out_free;
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/salc_datapath.sv =====
// ----------------------------------------------------------------------------
// salc_datapath
// Set memory, tag compare, LRU rank update, counters and register file.
// ----------------------------------------------------------------------------
module salc_datapath
   import salc_pkg::*;
#(
   parameter int MAX_SETS   = 64,
   parameter int MAX_WAYS   = 8,
   parameter int ADDR_WIDTH = 64
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  salc_cmd_type           cmd,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic [OP_W-1:0]        req_op,
   input  logic [ADDR_PORT_W-1:0] req_addr,
   output logic [OUTCOME_W-1:0]   rsp_outcome,
   output logic                   rsp_extra_hit,
   output logic [CNT_W-1:0]       rsp_hit_total,
   output logic [CNT_W-1:0]       rsp_miss_total,
   output logic [CNT_W-1:0]       rsp_evict_total
);

   localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int AGE_W  = WAY_W;
   localparam int TAG_W  = ADDR_WIDTH;
   localparam int RAW_N  = 2 ** RAW_IDX_W;
   localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);
   localparam logic [CNT_W:0]   CNT_TOP = {1'b0, {CNT_W{1'b1}}};

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                                input logic [1:0] inc);
      logic [CNT_W:0] sum;
      sum = {1'b0, c} + (CNT_W+1)'(inc);
      return (sum > CNT_TOP) ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
   endfunction

   // Configuration registers.
   logic [SET_BITS_W-1:0]   set_bits_ff;
   logic [BLOCK_BITS_W-1:0] block_bits_ff;
   logic [WAYS_W-1:0]       ways_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= '0;
         block_bits_ff <= '0;
         ways_ff       <= WAYS_W'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SET_BITS:   set_bits_ff   <= csr_data[SET_BITS_W-1:0];
            CSR_BLOCK_BITS: block_bits_ff <= csr_data[BLOCK_BITS_W-1:0];
            CSR_WAYS:       ways_ff       <= csr_data[WAYS_W-1:0];
            default:        ;
         endcase
      end
   end

   // Set index of the incoming request.
   logic [SET_W-1:0]     set_map [RAW_N];
   logic [TAG_W-1:0]     cap_block;
   logic [RAW_IDX_W-1:0] cap_raw;
   logic [SET_W-1:0]     cap_set;

   for (genvar g = 0; g < RAW_N; g++) begin : g_set_map
      assign set_map[g] = SET_W'(g % MAX_SETS);
   end

   assign cap_block = req_addr[ADDR_WIDTH-1:0] >> block_bits_ff;
   assign cap_raw   = cap_block[RAW_IDX_W-1:0]
                      & RAW_IDX_W'((8'd1 << set_bits_ff) - 8'd1);
   assign cap_set   = set_map[cap_raw];

   // Set memory: one row per set.
   logic [MAX_WAYS-1:0][TAG_W-1:0] tag_mem   [MAX_SETS];
   logic [MAX_WAYS-1:0]            valid_mem [MAX_SETS];
   logic [MAX_WAYS-1:0][AGE_W-1:0] age_mem   [MAX_SETS];
   logic [MAX_SETS-1:0]            row_init_ff;

   logic [MAX_WAYS-1:0][TAG_W-1:0] rd_tag_ff;
   logic [MAX_WAYS-1:0]            rd_valid_ff;
   logic [MAX_WAYS-1:0][AGE_W-1:0] rd_age_ff;
   logic                           rd_init_ff;
   logic [SET_W-1:0]               set_ff;
   logic [TAG_W-1:0]               block_ff;
   logic [OP_W-1:0]                op_ff;

   logic [MAX_WAYS-1:0][TAG_W-1:0] new_tag;
   logic [MAX_WAYS-1:0]            new_valid;
   logic [MAX_WAYS-1:0][AGE_W-1:0] new_age;
   logic                           op_known;
   logic                           mem_write;

   assign op_known  = (op_ff == OP_LOAD) || (op_ff == OP_STORE) || (op_ff == OP_MODIFY);
   assign mem_write = cmd.commit && op_known;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_tag_ff   <= tag_mem[cap_set];
         rd_valid_ff <= valid_mem[cap_set];
         rd_age_ff   <= age_mem[cap_set];
         rd_init_ff  <= row_init_ff[cap_set];
         set_ff      <= cap_set;
         block_ff    <= cap_block;
         op_ff       <= req_op;
      end
      if (mem_write) begin
         tag_mem[set_ff]   <= new_tag;
         valid_mem[set_ff] <= new_valid;
         age_mem[set_ff]   <= new_age;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_init_ff <= '0;
      end else if (mem_write) begin
         row_init_ff[set_ff] <= 1'b1;
      end
   end

   // Lookup and replacement.
   logic [ACTIVE_W-1:0]            n_active;
   logic [MAX_WAYS-1:0]            active;
   logic [MAX_WAYS-1:0]            valid_eff;
   logic [MAX_WAYS-1:0][AGE_W-1:0] age_eff;
   logic [MAX_WAYS-1:0]            match;
   logic                           hit;
   logic [WAY_W-1:0]               hit_way;
   logic                           has_empty;
   logic [WAY_W-1:0]               empty_way;
   logic [WAY_W-1:0]               victim;
   logic [AGE_W-1:0]               victim_age;
   logic [WAY_W-1:0]               sel_way;
   logic [AGE_W-1:0]               sel_age;
   logic                           miss;

   always_comb begin
      priority if (ways_ff == '0) begin
         n_active = ACTIVE_W'(1);
      end else if (ACTIVE_W'(ways_ff) > ACTIVE_W'(MAX_WAYS)) begin
         n_active = ACTIVE_W'(MAX_WAYS);
      end else begin
         n_active = ACTIVE_W'(ways_ff);
      end
   end

   for (genvar i = 0; i < MAX_WAYS; i++) begin : g_way
      assign active[i]    = ACTIVE_W'(i) < n_active;
      assign valid_eff[i] = rd_init_ff && rd_valid_ff[i];
      assign age_eff[i]   = rd_init_ff ? rd_age_ff[i] : '0;
      assign match[i]     = active[i] && valid_eff[i] && (rd_tag_ff[i] == block_ff);
   end

   always_comb begin
      hit        = 1'b0;
      hit_way    = '0;
      has_empty  = 1'b0;
      empty_way  = '0;
      victim     = '0;
      victim_age = age_eff[0];
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit     = 1'b1;
            hit_way = WAY_W'(i);
         end
         if (active[i] && !valid_eff[i]) begin
            has_empty = 1'b1;
            empty_way = WAY_W'(i);
         end
      end
      for (int i = 1; i < MAX_WAYS; i++) begin
         if (active[i] && (age_eff[i] > victim_age)) begin
            victim     = WAY_W'(i);
            victim_age = age_eff[i];
         end
      end
   end

   assign miss    = !hit;
   assign sel_way = hit ? hit_way : (has_empty ? empty_way : victim);
   assign sel_age = age_eff[sel_way];

   always_comb begin
      new_tag   = rd_tag_ff;
      new_valid = valid_eff;
      new_age   = age_eff;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (WAY_W'(i) == sel_way) begin
            new_age[i] = '0;
            if (miss) begin
               new_tag[i]   = block_ff;
               new_valid[i] = 1'b1;
            end
         end else if (active[i] && valid_eff[i] && (age_eff[i] < AGE_MAX)
                      && (miss || (age_eff[i] < sel_age))) begin
            new_age[i] = age_eff[i] + AGE_W'(1);
         end
      end
   end

   // Counters and response fields.
   logic [CNT_W-1:0]     hit_cnt_ff;
   logic [CNT_W-1:0]     miss_cnt_ff;
   logic [CNT_W-1:0]     evict_cnt_ff;
   logic [OUTCOME_W-1:0] outcome_ff;
   logic [OUTCOME_W-1:0] outcome_in;
   logic                 extra_ff;
   logic                 extra_in;
   logic [1:0]           hit_inc;
   logic                 miss_inc;
   logic                 evict_inc;

   assign extra_in  = (op_ff == OP_MODIFY);
   assign hit_inc   = {1'b0, op_known && hit} + {1'b0, extra_in};
   assign miss_inc  = op_known && miss;
   assign evict_inc = op_known && miss && !has_empty;

   always_comb begin
      priority if (!op_known || hit) begin
         outcome_in = OUTCOME_HIT;
      end else if (has_empty) begin
         outcome_in = OUTCOME_FILL;
      end else begin
         outcome_in = OUTCOME_EVICT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         evict_cnt_ff <= '0;
      end else if (cmd.commit) begin
         hit_cnt_ff   <= sat_add(hit_cnt_ff, hit_inc);
         miss_cnt_ff  <= sat_add(miss_cnt_ff, {1'b0, miss_inc});
         evict_cnt_ff <= sat_add(evict_cnt_ff, {1'b0, evict_inc});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         outcome_ff <= outcome_in;
         extra_ff   <= extra_in;
      end
   end

   assign rsp_outcome     = outcome_ff;
   assign rsp_extra_hit   = extra_ff;
   assign rsp_hit_total   = hit_cnt_ff;
   assign rsp_miss_total  = miss_cnt_ff;
   assign rsp_evict_total = evict_cnt_ff;

endmodule

// ===== hw/rtl/set_assoc_lru_cache_model.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// Set-associative cache model with true LRU replacement and hit counters.
// ----------------------------------------------------------------------------
// Requests (req_op, req_addr) arrive on a valid/ready channel; each beat
// yields one response beat with the outcome, the extra-hit flag of a modify
// and the saturating hit, miss and eviction totals after that access.
// The accepting edge reads the set row from the set memory; in the update
// state the tags are compared, the ways ranked and the row written back.
// The single set-memory port and this read-modify-write loop keep a new
// request out until the last one is written back, when the response is
// registered. While a response waits for rsp_ready, the update of the
// next item holds, so at most one finished beat and one item in flight exist.
// Configuration writes on the csr_ channel are always taken.
// Synchronous reset empties the cache through per-set row flags, clears
// the counters and loads set_bits 0, block_bits 0 and ways 1.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model
   import salc_pkg::*;
#(
   parameter int MAX_SETS   = 64,
   parameter int MAX_WAYS   = 8,
   parameter int ADDR_WIDTH = 64
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [OP_W-1:0]        req_op,
   input  logic [ADDR_PORT_W-1:0] req_addr,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [OUTCOME_W-1:0]   rsp_outcome,
   output logic                   rsp_extra_hit,
   output logic [CNT_W-1:0]       rsp_hit_total,
   output logic [CNT_W-1:0]       rsp_miss_total,
   output logic [CNT_W-1:0]       rsp_evict_total
);

   salc_cmd_type cmd;

   assign csr_ready = 1'b1;

   salc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   salc_datapath #(
      .MAX_SETS   (MAX_SETS),
      .MAX_WAYS   (MAX_WAYS),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .csr_write       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_op          (req_op),
      .req_addr        (req_addr),
      .rsp_outcome     (rsp_outcome),
      .rsp_extra_hit   (rsp_extra_hit),
      .rsp_hit_total   (rsp_hit_total),
      .rsp_miss_total  (rsp_miss_total),
      .rsp_evict_total (rsp_evict_total)
   );

endmodule
